/* sv/rev_pkg.sv */
// ----------------------------------------------------------------------------
// rev_pkg
// Shared constants and control types for the ribbon edge vertex pair block.
// ----------------------------------------------------------------------------
package rev_pkg;

   localparam int COORD_BITS_DEFAULT = 24;
   localparam int NORMAL_BITS        = 16;
   localparam int HW_BITS            = 16;
   localparam int FRAC_SHIFT         = 14;
   localparam int DIGIT_BITS         = 16;
   localparam int LANES              = 3;
   localparam int LANE_BITS          = 2;

   localparam logic [HW_BITS-1:0] BASE_HW_RESET = 16'd192;

   typedef struct packed {
      logic capture;
      logic scale;
      logic build_edges;
      logic prep;
      logic mac_issue;
      logic mac_add;
      logic decide;
   } rev_cmd_type;

   typedef struct packed {
      logic use_last;
      logic mac_last;
   } rev_status_type;

endpackage

/* sv/rev_ctrl.sv */
// ----------------------------------------------------------------------------
// rev_ctrl
// Sequencer: accepts one word, steps the datapath through scaling, edge
// building, the distance compare (only with a kept vertex) and the output
// load.
module rev_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rev_pkg::rev_cmd_type    cmd,
   input  rev_pkg::rev_status_type status
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCALE  = 7'b0000010,
      ST_EDGES  = 7'b0000100,
      ST_PREP   = 7'b0001000,
      ST_MAC    = 7'b0010000,
      ST_DRAIN  = 7'b0100000,
      ST_DECIDE = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EDGES;
         end
         ST_EDGES: begin
            cmd.build_edges = 1'b1;
            state_in        = status.use_last ? ST_PREP : ST_DECIDE;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            cmd.mac_add   = 1'b1;
            if (status.mac_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.mac_add = 1'b1;
            state_in    = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.decide = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.decide) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/rev_dp.sv */
// ----------------------------------------------------------------------------
// rev_dp
// Datapath: normal scaling, saturated edge points, digit-serial signed
// distance compare against the kept vertex, ordered output registers.
// ----------------------------------------------------------------------------
module rev_dp #(
   parameter int COORD_BITS = rev_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rev_pkg::rev_cmd_type                cmd,
   output rev_pkg::rev_status_type             status,
   input  logic                                csr_valid,
   input  logic [rev_pkg::HW_BITS-1:0]         csr_base_half_width,
   input  logic signed [COORD_BITS-1:0]        req_pos_x,
   input  logic signed [COORD_BITS-1:0]        req_pos_y,
   input  logic signed [COORD_BITS-1:0]        req_pos_z,
   input  logic signed [rev_pkg::NORMAL_BITS-1:0] req_normal_x,
   input  logic signed [rev_pkg::NORMAL_BITS-1:0] req_normal_y,
   input  logic signed [rev_pkg::NORMAL_BITS-1:0] req_normal_z,
   input  logic [rev_pkg::HW_BITS-1:0]         req_thickness,
   input  logic                                req_restart,
   output logic signed [COORD_BITS-1:0]        rsp_first_x,
   output logic signed [COORD_BITS-1:0]        rsp_first_y,
   output logic signed [COORD_BITS-1:0]        rsp_first_z,
   output logic signed [COORD_BITS-1:0]        rsp_second_x,
   output logic signed [COORD_BITS-1:0]        rsp_second_y,
   output logic signed [COORD_BITS-1:0]        rsp_second_z,
   output logic                                rsp_swapped
);

   localparam int NRM_W     = rev_pkg::NORMAL_BITS;
   localparam int HW_W      = rev_pkg::HW_BITS + 1;
   localparam int PROD_W    = NRM_W + HW_W + 1;
   localparam int OFF_W     = PROD_W - rev_pkg::FRAC_SHIFT;
   localparam int SUM_W     = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 1;
   localparam int DIFF_W    = COORD_BITS + 1;
   localparam int TERM_W    = COORD_BITS + 3;
   localparam int MAGD_W    = COORD_BITS;
   localparam int MAGT_W    = COORD_BITS + 1;
   localparam int DIG_W     = rev_pkg::DIGIT_BITS;
   localparam int NDIG      = (MAGT_W + DIG_W - 1) / DIG_W;
   localparam int PAD_W     = NDIG * DIG_W;
   localparam int DIG_CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int PP_W      = MAGD_W + DIG_W;
   localparam int ACC_W     = 2 * COORD_BITS + 4;
   localparam int LANES     = rev_pkg::LANES;
   localparam int LANE_W    = rev_pkg::LANE_BITS;

   localparam logic signed [PROD_W-1:0] ROUND_BIAS =
      PROD_W'(2 ** (rev_pkg::FRAC_SHIFT - 1));
   localparam logic signed [SUM_W-1:0] SAT_MAX =
      {{(SUM_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;
   localparam logic [DIG_CNT_W-1:0] DIG_LAST  = DIG_CNT_W'(NDIG - 1);
   localparam logic [LANE_W-1:0]    LANE_LAST = LANE_W'(LANES - 1);

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v
   );
      if (v > SAT_MAX) begin
         return SAT_MAX[COORD_BITS-1:0];
      end else if (v < SAT_MIN) begin
         return SAT_MIN[COORD_BITS-1:0];
      end
      return v[COORD_BITS-1:0];
   endfunction

   // control and architectural state
   logic [rev_pkg::HW_BITS-1:0]  base_hw_ff, base_hw_in;
   logic signed [COORD_BITS-1:0] last_ff [LANES];
   logic signed [COORD_BITS-1:0] last_in [LANES];
   logic                         have_last_ff, have_last_in;
   logic [LANE_W-1:0]            lane_ff, lane_in;
   logic [DIG_CNT_W-1:0]         dig_ff, dig_in;
   logic [PP_W-1:0]              pp_ff, pp_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;

   // payload
   logic signed [COORD_BITS-1:0] pos_ff [LANES];
   logic signed [COORD_BITS-1:0] pos_in [LANES];
   logic signed [NRM_W-1:0]      nrm_ff [LANES];
   logic signed [NRM_W-1:0]      nrm_in [LANES];
   logic [rev_pkg::HW_BITS-1:0]  thick_ff, thick_in;
   logic                         restart_ff, restart_in;
   logic signed [OFF_W-1:0]      off_ff [LANES];
   logic signed [OFF_W-1:0]      off_in [LANES];
   logic signed [COORD_BITS-1:0] edge_a_ff [LANES];
   logic signed [COORD_BITS-1:0] edge_a_in [LANES];
   logic signed [COORD_BITS-1:0] edge_b_ff [LANES];
   logic signed [COORD_BITS-1:0] edge_b_in [LANES];
   logic [MAGD_W-1:0]            magd_ff [LANES];
   logic [MAGD_W-1:0]            magd_in [LANES];
   logic [MAGT_W-1:0]            magt_ff [LANES];
   logic [MAGT_W-1:0]            magt_in [LANES];
   logic                         neg_ff [LANES];
   logic                         neg_in [LANES];
   logic [DIG_CNT_W-1:0]         pp_shift_ff, pp_shift_in;
   logic                         pp_neg_ff, pp_neg_in;
   logic signed [COORD_BITS-1:0] first_ff [LANES];
   logic signed [COORD_BITS-1:0] first_in [LANES];
   logic signed [COORD_BITS-1:0] second_ff [LANES];
   logic signed [COORD_BITS-1:0] second_in [LANES];
   logic                         swapped_ff, swapped_in;

   // combinational temporaries
   logic [HW_W-1:0]              hw;
   logic signed [PROD_W-1:0]     prod [LANES];
   logic signed [PROD_W-1:0]     rnd [LANES];
   logic signed [SUM_W-1:0]      sum_p [LANES];
   logic signed [SUM_W-1:0]      sum_m [LANES];
   logic signed [DIFF_W-1:0]     diff [LANES];
   logic signed [TERM_W-1:0]     term [LANES];
   logic [PAD_W-1:0]             magt_pad;
   logic [DIG_W-1:0]             digit;
   logic [ACC_W-1:0]             shifted;
   logic                         use_last;
   logic                         swap;

   assign use_last = have_last_ff & ~restart_ff;
   assign swap     = use_last & acc_ff[ACC_W-1];

   assign status.use_last = use_last;
   assign status.mac_last = (lane_ff == LANE_LAST) && (dig_ff == DIG_LAST);

   assign hw = HW_W'(base_hw_ff) + HW_W'(thick_ff);

   // capture, scale, edges, compare terms
   always_comb begin
      pos_in[0]  = req_pos_x;
      pos_in[1]  = req_pos_y;
      pos_in[2]  = req_pos_z;
      nrm_in[0]  = req_normal_x;
      nrm_in[1]  = req_normal_y;
      nrm_in[2]  = req_normal_z;
      thick_in   = req_thickness;
      restart_in = req_restart;
      for (int k = 0; k < LANES; k++) begin
         prod[k]      = PROD_W'(nrm_ff[k]) * $signed(PROD_W'(hw));
         rnd[k]       = prod[k] + ROUND_BIAS;
         off_in[k]    = OFF_W'(rnd[k] >>> rev_pkg::FRAC_SHIFT);
         sum_p[k]     = SUM_W'(pos_ff[k]) + SUM_W'(off_ff[k]);
         sum_m[k]     = SUM_W'(pos_ff[k]) - SUM_W'(off_ff[k]);
         edge_a_in[k] = sat_coord(sum_p[k]);
         edge_b_in[k] = sat_coord(sum_m[k]);
         diff[k]      = DIFF_W'(edge_a_ff[k]) - DIFF_W'(edge_b_ff[k]);
         term[k]      = TERM_W'(edge_a_ff[k]) + TERM_W'(edge_b_ff[k])
                        - (TERM_W'(last_ff[k]) <<< 1);
         magd_in[k]   = diff[k][DIFF_W-1] ? MAGD_W'(-diff[k]) : MAGD_W'(diff[k]);
         magt_in[k]   = term[k][TERM_W-1] ? MAGT_W'(-term[k]) : MAGT_W'(term[k]);
         neg_in[k]    = diff[k][DIFF_W-1] ^ term[k][TERM_W-1];
      end
   end

   // digit-serial multiply-accumulate of (a-b)*(a+b-2v) over the lanes
   always_comb begin
      magt_pad    = PAD_W'(magt_ff[lane_ff]);
      digit       = magt_pad[dig_ff * DIG_W +: DIG_W];
      pp_shift_in = pp_shift_ff;
      pp_neg_in   = pp_neg_ff;
      shifted     = ACC_W'(pp_ff) << (DIG_W * pp_shift_ff);
      pp_in       = pp_ff;
      acc_in      = acc_ff;
      lane_in     = lane_ff;
      dig_in      = dig_ff;
      if (cmd.prep) begin
         pp_in       = '0;
         acc_in      = '0;
         lane_in     = '0;
         dig_in      = '0;
         pp_shift_in = '0;
         pp_neg_in   = 1'b0;
      end else begin
         if (cmd.mac_issue) begin
            pp_in       = PP_W'(magd_ff[lane_ff]) * PP_W'(digit);
            pp_shift_in = dig_ff;
            pp_neg_in   = neg_ff[lane_ff];
            if (dig_ff == DIG_LAST) begin
               dig_in  = '0;
               lane_in = lane_ff + LANE_W'(1);
            end else begin
               dig_in = dig_ff + DIG_CNT_W'(1);
            end
         end
         if (cmd.mac_add) begin
            acc_in = pp_neg_ff ? (acc_ff - shifted) : (acc_ff + shifted);
         end
      end
   end

   // order the pair and keep the second point
   always_comb begin
      base_hw_in   = csr_valid ? csr_base_half_width : base_hw_ff;
      have_last_in = have_last_ff | cmd.decide;
      swapped_in   = swap;
      for (int k = 0; k < LANES; k++) begin
         first_in[k]  = swap ? edge_b_ff[k] : edge_a_ff[k];
         second_in[k] = swap ? edge_a_ff[k] : edge_b_ff[k];
         last_in[k]   = cmd.decide ? second_in[k] : last_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_hw_ff   <= rev_pkg::BASE_HW_RESET;
         have_last_ff <= 1'b0;
         lane_ff      <= '0;
         dig_ff       <= '0;
         pp_ff        <= '0;
         acc_ff       <= '0;
         pp_shift_ff  <= '0;
         pp_neg_ff    <= 1'b0;
         for (int k = 0; k < LANES; k++) begin
            last_ff[k] <= '0;
         end
      end else begin
         base_hw_ff   <= base_hw_in;
         have_last_ff <= have_last_in;
         lane_ff      <= lane_in;
         dig_ff       <= dig_in;
         pp_ff        <= pp_in;
         acc_ff       <= acc_in;
         pp_shift_ff  <= pp_shift_in;
         pp_neg_ff    <= pp_neg_in;
         for (int k = 0; k < LANES; k++) begin
            last_ff[k] <= last_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         thick_ff   <= thick_in;
         restart_ff <= restart_in;
         for (int k = 0; k < LANES; k++) begin
            pos_ff[k] <= pos_in[k];
            nrm_ff[k] <= nrm_in[k];
         end
      end
      if (cmd.scale) begin
         for (int k = 0; k < LANES; k++) begin
            off_ff[k] <= off_in[k];
         end
      end
      if (cmd.build_edges) begin
         for (int k = 0; k < LANES; k++) begin
            edge_a_ff[k] <= edge_a_in[k];
            edge_b_ff[k] <= edge_b_in[k];
         end
      end
      if (cmd.prep) begin
         for (int k = 0; k < LANES; k++) begin
            magd_ff[k] <= magd_in[k];
            magt_ff[k] <= magt_in[k];
            neg_ff[k]  <= neg_in[k];
         end
      end
      if (cmd.decide) begin
         swapped_ff <= swapped_in;
         for (int k = 0; k < LANES; k++) begin
            first_ff[k]  <= first_in[k];
            second_ff[k] <= second_in[k];
         end
      end
   end

   assign rsp_first_x  = first_ff[0];
   assign rsp_first_y  = first_ff[1];
   assign rsp_first_z  = first_ff[2];
   assign rsp_second_x = second_ff[0];
   assign rsp_second_y = second_ff[1];
   assign rsp_second_z = second_ff[2];
   assign rsp_swapped  = swapped_ff;

endmodule

/* sv/ribbon_edge_vertex_pair_top.sv */
// ----------------------------------------------------------------------------
// ribbon_edge_vertex_pair_top
// Builds the two saturated ribbon edge points of a curve point and orders
// them by squared distance to the last emitted vertex.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  position, normal, thickness, restart
//   rsp      out        rsp_valid/rsp_stall  ordered edge pair, swapped flag
//   csr      in         csr_valid/csr_ready  base half width
//
// One word at a time. With a kept vertex the distance compare runs the
// three lanes digit by digit through one shared 16-bit-digit multiplier.
// On restart or with no kept vertex the compare is skipped.
// Synchronous reset restores the base half width to 192 and drops the kept
// vertex. The output register holds a stalled result while the next word
// is taken and worked on.
// ----------------------------------------------------------------------------
module ribbon_edge_vertex_pair_top #(
   parameter int COORD_BITS = rev_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_BITS-1:0]           req_pos_x,
   input  logic signed [COORD_BITS-1:0]           req_pos_y,
   input  logic signed [COORD_BITS-1:0]           req_pos_z,
   input  logic signed [rev_pkg::NORMAL_BITS-1:0] req_normal_x,
   input  logic signed [rev_pkg::NORMAL_BITS-1:0] req_normal_y,
   input  logic signed [rev_pkg::NORMAL_BITS-1:0] req_normal_z,
   input  logic [rev_pkg::HW_BITS-1:0]            req_thickness,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [COORD_BITS-1:0]           rsp_first_x,
   output logic signed [COORD_BITS-1:0]           rsp_first_y,
   output logic signed [COORD_BITS-1:0]           rsp_first_z,
   output logic signed [COORD_BITS-1:0]           rsp_second_x,
   output logic signed [COORD_BITS-1:0]           rsp_second_y,
   output logic signed [COORD_BITS-1:0]           rsp_second_z,
   output logic                                   rsp_swapped,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rev_pkg::HW_BITS-1:0]            csr_base_half_width
);

   rev_pkg::rev_cmd_type    cmd;
   rev_pkg::rev_status_type status;

   assign csr_ready = 1'b1;

   rev_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rev_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_valid           (csr_valid),
      .csr_base_half_width (csr_base_half_width),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_pos_z           (req_pos_z),
      .req_normal_x        (req_normal_x),
      .req_normal_y        (req_normal_y),
      .req_normal_z        (req_normal_z),
      .req_thickness       (req_thickness),
      .req_restart         (req_restart),
      .rsp_first_x         (rsp_first_x),
      .rsp_first_y         (rsp_first_y),
      .rsp_first_z         (rsp_first_z),
      .rsp_second_x        (rsp_second_x),
      .rsp_second_y        (rsp_second_y),
      .rsp_second_z        (rsp_second_z),
      .rsp_swapped         (rsp_swapped)
   );

endmodule
